// ===== rtl/hmbd_pkg.sv =====
// Shared types, codes and region decode for the handheld memory bus decoder.
`timescale 1ns / 1ps

package hmbd_pkg;

  // Bus commands
  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_PRELOAD = 2'd2;

  // Access sizes; the other two codes are taken as a word
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // Top address byte of each region
  localparam logic [7:0] RBYTE_BOOT     = 8'h00;
  localparam logic [7:0] RBYTE_EXT      = 8'h02;
  localparam logic [7:0] RBYTE_INT      = 8'h03;
  localparam logic [7:0] RBYTE_IO       = 8'h04;
  localparam logic [7:0] RBYTE_VIDEO_LO = 8'h05;
  localparam logic [7:0] RBYTE_VIDEO_HI = 8'h07;
  localparam logic [7:0] RBYTE_CART_LO  = 8'h08;
  localparam logic [7:0] RBYTE_CART_HI  = 8'h0D;

  // Forwarding codes on the result word
  localparam logic [1:0] FWD_NONE  = 2'd0;
  localparam logic [1:0] FWD_IO    = 2'd1;
  localparam logic [1:0] FWD_VIDEO = 2'd2;

  // Wait cycle charges
  localparam logic [2:0] WAIT_NONE     = 3'd0;
  localparam logic [2:0] WAIT_ONE      = 3'd1;
  localparam logic [2:0] WAIT_EXT_SHORT = 3'd3;
  localparam logic [2:0] WAIT_CART     = 3'd5;
  localparam logic [2:0] WAIT_EXT_WORD = 3'd6;

  typedef enum logic [2:0] {
    RG_NONE,
    RG_BOOT,
    RG_EXT,
    RG_INT,
    RG_IO,
    RG_VIDEO,
    RG_CART
  } region_e;

  // Map the top address byte to a region class
  function automatic region_e decode_region(logic [7:0] rbyte);
    region_e rg;
    rg = RG_NONE;
    if (rbyte == RBYTE_BOOT) begin
      rg = RG_BOOT;
    end else if (rbyte == RBYTE_EXT) begin
      rg = RG_EXT;
    end else if (rbyte == RBYTE_INT) begin
      rg = RG_INT;
    end else if (rbyte == RBYTE_IO) begin
      rg = RG_IO;
    end else if (rbyte >= RBYTE_VIDEO_LO && rbyte <= RBYTE_VIDEO_HI) begin
      rg = RG_VIDEO;
    end else if (rbyte >= RBYTE_CART_LO && rbyte <= RBYTE_CART_HI) begin
      rg = RG_CART;
    end
    return rg;
  endfunction

endpackage

// ===== rtl/handheld_memory_bus_decoder.sv =====
// Top level of the handheld memory bus decoder: region decode, byte-lane RAMs, result word.
`timescale 1ns / 1ps

// One bus access per input word, one result word per access. In the accept cycle the
// address, lane enables and shifted write data go straight to the byte-lane RAMs of
// the selected region (four 8-bit RAMs per memory region, one per lane of a 32-bit row);
// in the next cycle the result word is formed (for a read, the registered RAM read shifted
// down and masked to the access size) and loaded into the output register. No new word is
// taken in that busy cycle, nor while the output register holds a word that is not taken.
// After reset the block clears both work RAMs, one row per cycle, and takes no input until
// the clearing pass has covered every row of the larger of the two.
// The boot and cartridge ROM stores are not cleared; load them by preload before reading.
module handheld_memory_bus_decoder #(
  parameter int EXT_RAM_ADDR_BITS  = 18,
  parameter int INT_RAM_ADDR_BITS  = 15,
  parameter int BOOT_ROM_ADDR_BITS = 14,
  parameter int CART_ROM_ADDR_BITS = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  size_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [2:0]  wait_cycles_o,
  output logic [1:0]  external_region_o,
  output logic [31:0] aligned_address_o
);

  import hmbd_pkg::*;

  localparam int EXT_ROW_BITS  = EXT_RAM_ADDR_BITS - 2;
  localparam int INT_ROW_BITS  = INT_RAM_ADDR_BITS - 2;
  localparam int BOOT_ROW_BITS = BOOT_ROM_ADDR_BITS - 2;
  localparam int CART_ROW_BITS = CART_ROM_ADDR_BITS - 2;
  localparam int CLR_BITS      = (EXT_ROW_BITS > INT_ROW_BITS) ? EXT_ROW_BITS : INT_ROW_BITS;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_BUSY  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CLR_BITS-1:0] clr_q, clr_d;
  logic                clearing;

  logic                in_accept;
  region_e             in_region;
  logic [31:0]         in_al;
  logic [3:0]          in_lane_en;
  logic [31:0]         in_wword;

  logic                ext_we, int_we, boot_we, cart_we;
  logic [EXT_ROW_BITS-1:0] ext_addr;
  logic [INT_ROW_BITS-1:0] int_addr;
  logic [31:0]         ext_wword, int_wword;

  logic [3:0][7:0]     ext_rd, int_rd, boot_rd, cart_rd;

  logic [1:0]          cmd_q, size_q;
  logic [31:0]         al_q;
  region_e             region_q;

  logic [31:0]         row_word;
  logic [31:0]         shifted;
  logic [31:0]         rd_val;
  logic [2:0]          wait_val;
  logic [1:0]          fwd_val;
  logic                is_word, is_half;

  logic                out_valid_q, out_valid_d;
  logic [31:0]         read_data_q;
  logic [2:0]          wait_cycles_q;
  logic [1:0]          external_region_q;
  logic [31:0]         aligned_address_q;

  assign clearing   = (state_q == ST_CLEAR);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;

  // Decode the incoming word: region, aligned address, lanes, lane data
  assign in_region = decode_region(address_i[31:24]);

  always_comb begin
    unique case (size_i)
      SIZE_BYTE: begin
        in_al      = address_i;
        in_lane_en = 4'b0001 << address_i[1:0];
      end
      SIZE_HALF: begin
        in_al      = {address_i[31:1], 1'b0};
        in_lane_en = address_i[1] ? 4'b1100 : 4'b0011;
      end
      default: begin
        in_al      = {address_i[31:2], 2'b00};
        in_lane_en = 4'b1111;
      end
    endcase
  end

  assign in_wword = write_data_i << {in_al[1:0], 3'b000};

  // Steer the RAM ports: clearing pass first, then bus accesses
  assign ext_we    = clearing ||
                     (in_accept && cmd_i == CMD_WRITE && in_region == RG_EXT);
  assign int_we    = clearing ||
                     (in_accept && cmd_i == CMD_WRITE && in_region == RG_INT);
  assign boot_we   = in_accept && cmd_i == CMD_PRELOAD && in_region == RG_BOOT;
  assign cart_we   = in_accept && cmd_i == CMD_PRELOAD && in_region == RG_CART;
  assign ext_addr  = clearing ? clr_q[EXT_ROW_BITS-1:0] : in_al[EXT_RAM_ADDR_BITS-1:2];
  assign int_addr  = clearing ? clr_q[INT_ROW_BITS-1:0] : in_al[INT_RAM_ADDR_BITS-1:2];
  assign ext_wword = clearing ? 32'd0 : in_wword;
  assign int_wword = clearing ? 32'd0 : in_wword;

  // One RAM per byte lane for each of the four memory regions
  for (genvar g = 0; g < 4; g++) begin : g_lane
    hmbd_ram #(
      .WIDTH (8),
      .DEPTH (2 ** EXT_ROW_BITS)
    ) u_ext_ram (
      .clk_i   (clk_i),
      .we_i    (ext_we && (clearing || in_lane_en[g])),
      .addr_i  (ext_addr),
      .wdata_i (ext_wword[8*g +: 8]),
      .rdata_o (ext_rd[g])
    );

    hmbd_ram #(
      .WIDTH (8),
      .DEPTH (2 ** INT_ROW_BITS)
    ) u_int_ram (
      .clk_i   (clk_i),
      .we_i    (int_we && (clearing || in_lane_en[g])),
      .addr_i  (int_addr),
      .wdata_i (int_wword[8*g +: 8]),
      .rdata_o (int_rd[g])
    );

    hmbd_ram #(
      .WIDTH (8),
      .DEPTH (2 ** BOOT_ROW_BITS)
    ) u_boot_rom (
      .clk_i   (clk_i),
      .we_i    (boot_we && in_lane_en[g]),
      .addr_i  (in_al[BOOT_ROM_ADDR_BITS-1:2]),
      .wdata_i (in_wword[8*g +: 8]),
      .rdata_o (boot_rd[g])
    );

    hmbd_ram #(
      .WIDTH (8),
      .DEPTH (2 ** CART_ROW_BITS)
    ) u_cart_rom (
      .clk_i   (clk_i),
      .we_i    (cart_we && in_lane_en[g]),
      .addr_i  (in_al[CART_ROM_ADDR_BITS-1:2]),
      .wdata_i (in_wword[8*g +: 8]),
      .rdata_o (cart_rd[g])
    );
  end

  // Sequence: clear pass, then accept / busy alternation
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Hold the access fields for the result cycle
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= cmd_i;
      size_q   <= size_i;
      al_q     <= in_al;
      region_q <= in_region;
    end
  end

  // Assemble the read value from the selected row
  always_comb begin
    unique case (region_q)
      RG_BOOT: row_word = boot_rd;
      RG_EXT:  row_word = ext_rd;
      RG_INT:  row_word = int_rd;
      RG_CART: row_word = cart_rd;
      default: row_word = 32'd0;
    endcase
  end

  assign is_half = (size_q == SIZE_HALF);
  assign is_word = (size_q != SIZE_BYTE) && !is_half;
  assign shifted = row_word >> {al_q[1:0], 3'b000};

  // Result fields from command, region and size
  always_comb begin
    rd_val   = 32'd0;
    wait_val = WAIT_NONE;
    fwd_val  = FWD_NONE;
    unique case (cmd_q)
      CMD_READ: begin
        unique case (region_q)
          RG_BOOT, RG_INT: wait_val = WAIT_ONE;
          RG_EXT:   wait_val = is_word ? WAIT_EXT_WORD : WAIT_EXT_SHORT;
          RG_CART:  wait_val = WAIT_CART;
          RG_IO: begin
            fwd_val  = FWD_IO;
            wait_val = is_half ? WAIT_NONE : WAIT_ONE;
          end
          RG_VIDEO: begin
            fwd_val  = FWD_VIDEO;
            wait_val = is_half ? WAIT_ONE : WAIT_NONE;
          end
          default: wait_val = WAIT_NONE;
        endcase
        if (is_word) begin
          rd_val = shifted;
        end else if (is_half) begin
          rd_val = {16'd0, shifted[15:0]};
        end else begin
          rd_val = {24'd0, shifted[7:0]};
        end
      end
      CMD_WRITE: begin
        unique case (region_q)
          RG_BOOT, RG_INT: wait_val = WAIT_ONE;
          RG_EXT:   wait_val = is_word ? WAIT_EXT_WORD : WAIT_EXT_SHORT;
          RG_IO: begin
            fwd_val  = FWD_IO;
            wait_val = WAIT_ONE;
          end
          RG_VIDEO: fwd_val = (size_q != SIZE_BYTE) ? FWD_VIDEO : FWD_NONE;
          default:  wait_val = WAIT_NONE;
        endcase
      end
      default: begin
        rd_val = 32'd0;
      end
    endcase
  end

  // Output register: load in the busy cycle, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == ST_BUSY) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_BUSY) begin
      read_data_q       <= rd_val;
      wait_cycles_q     <= wait_val;
      external_region_q <= fwd_val;
      aligned_address_q <= (fwd_val != FWD_NONE) ? al_q : 32'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = read_data_q;
  assign wait_cycles_o     = wait_cycles_q;
  assign external_region_o = external_region_q;
  assign aligned_address_o = aligned_address_q;

  // Checks on sequencing
  a_accept_to_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == ST_BUSY)
    else $error("accepted word did not enter the busy cycle");

  a_busy_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BUSY |-> !out_valid_q)
    else $error("output register occupied when a result is due");

  a_result_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_BUSY))
    else $error("result word appeared without a busy cycle");

  a_clear_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q == ST_CLEAR) |-> $past(&clr_q))
    else $error("clearing pass ended before the last row");

  a_rom_write_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (boot_we || cart_we) |-> in_accept && !clearing)
    else $error("ROM store written outside an accepted preload");

endmodule

// ===== rtl/hmbd_ram.sv =====
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps

module hmbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and read the old contents through a register in the next cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
